// ===== hdl/rtcl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the cartridge real-time clock.
package rtcl_pkg;

	// Depth of the queue between the decode pipeline and the register file.
	localparam int QUEUE_DEPTH = 8;

	// Operation codes on the input channel.
	localparam logic [1:0] OP_ADVANCE = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_WRITE   = 2'd2;
	localparam logic [1:0] OP_LATCH   = 2'd3;

	// Register indexes.
	localparam int REG_COUNT = 5;
	localparam logic [2:0] REG_SEC  = 3'd0;
	localparam logic [2:0] REG_MIN  = 3'd1;
	localparam logic [2:0] REG_HOUR = 3'd2;
	localparam logic [2:0] REG_DAYL = 3'd3;
	localparam logic [2:0] REG_DAYH = 3'd4;

	// Reciprocals for exact division of any 32-bit value by 60 and by 24.
	localparam logic [31:0] DIV60_MUL   = 32'h8888_8889;
	localparam int          DIV60_SHIFT = 37;
	localparam logic [31:0] DIV24_MUL   = 32'hAAAA_AAAB;
	localparam int          DIV24_SHIFT = 36;

	// Moduli of the time fields.
	localparam logic [7:0] SEC_MOD  = 8'd60;
	localparam logic [7:0] MIN_MOD  = 8'd60;
	localparam logic [7:0] HOUR_MOD = 8'd24;

	// Work handed from the decode pipeline to the register file.
	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_ADVANCE,
		KIND_READ,
		KIND_WRITE,
		KIND_LATCH
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  idx;
		logic [7:0]  wdata;
		logic [7:0]  ldata;
		logic [5:0]  sec_part;
		logic [5:0]  min_part;
		logic [4:0]  hour_part;
		logic [15:0] day_part;
	} item_t;

endpackage

// ===== hdl/rtcl_front.sv =====
`timescale 1ns / 1ps
// Decode pipeline: classifies operations and splits elapsed seconds into fields.
module rtcl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_take,
	input  logic [1:0]          operation,
	input  logic [31:0]         elapsed_seconds,
	input  logic [2:0]          register_index,
	input  logic [7:0]          write_data,
	input  logic [7:0]          latch_data,
	output logic                push,
	output rtcl_pkg::item_t     push_item
);

	// Stage 1: inputs and first reciprocal product.
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [2:0]  idx_s1;
	logic [7:0]  wdata_s1;
	logic [7:0]  ldata_s1;
	logic [31:0] elapsed_s1;
	logic        nonzero_s1;
	logic [63:0] prod1_s1;

	// Stage 2: seconds field and second reciprocal product.
	logic        valid_s2;
	logic [1:0]  op_s2;
	logic [2:0]  idx_s2;
	logic [7:0]  wdata_s2;
	logic [7:0]  ldata_s2;
	logic        nonzero_s2;
	logic [5:0]  sec_s2;
	logic [26:0] q1_s2;
	logic [57:0] prod2_s2;

	// Stage 3: minutes field and third reciprocal product.
	logic        valid_s3;
	logic [1:0]  op_s3;
	logic [2:0]  idx_s3;
	logic [7:0]  wdata_s3;
	logic [7:0]  ldata_s3;
	logic        nonzero_s3;
	logic [5:0]  sec_s3;
	logic [5:0]  min_s3;
	logic [20:0] q2_s3;
	logic [51:0] prod3_s3;

	logic [26:0] q1_d;
	logic [31:0] sec_full;
	logic [20:0] q2_d;
	logic [26:0] min_full;
	logic [15:0] days_d;
	logic [20:0] hour_full;
	rtcl_pkg::kind_t kind_d;

	assign q1_d     = prod1_s1[63:rtcl_pkg::DIV60_SHIFT];
	assign sec_full = elapsed_s1 - (32'(q1_d) * 32'd60);
	assign q2_d     = prod2_s2[57:rtcl_pkg::DIV60_SHIFT];
	assign min_full = q1_s2 - (27'(q2_d) * 27'd60);
	assign days_d   = prod3_s3[51:rtcl_pkg::DIV24_SHIFT];
	assign hour_full = q2_s3 - (21'(days_d) * 21'd24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1      <= operation;
		idx_s1     <= register_index;
		wdata_s1   <= write_data;
		ldata_s1   <= latch_data;
		elapsed_s1 <= elapsed_seconds;
		nonzero_s1 <= |elapsed_seconds;
		prod1_s1   <= 64'(elapsed_seconds) * 64'(rtcl_pkg::DIV60_MUL);

		op_s2      <= op_s1;
		idx_s2     <= idx_s1;
		wdata_s2   <= wdata_s1;
		ldata_s2   <= ldata_s1;
		nonzero_s2 <= nonzero_s1;
		sec_s2     <= sec_full[5:0];
		q1_s2      <= q1_d;
		prod2_s2   <= 58'(q1_d) * 58'(rtcl_pkg::DIV60_MUL);

		op_s3      <= op_s2;
		idx_s3     <= idx_s2;
		wdata_s3   <= wdata_s2;
		ldata_s3   <= ldata_s2;
		nonzero_s3 <= nonzero_s2;
		sec_s3     <= sec_s2;
		min_s3     <= min_full[5:0];
		q2_s3      <= q2_d;
		prod3_s3   <= 52'(q2_d) * 52'(rtcl_pkg::DIV24_MUL);
	end

	// An advance of nothing and a write to a missing register do no work.
	always_comb begin
		case (op_s3)
			rtcl_pkg::OP_ADVANCE: kind_d = nonzero_s3 ? rtcl_pkg::KIND_ADVANCE
				: rtcl_pkg::KIND_NOP;
			rtcl_pkg::OP_READ:    kind_d = rtcl_pkg::KIND_READ;
			rtcl_pkg::OP_WRITE:   kind_d = (idx_s3 < 3'(rtcl_pkg::REG_COUNT))
				? rtcl_pkg::KIND_WRITE : rtcl_pkg::KIND_NOP;
			rtcl_pkg::OP_LATCH:   kind_d = rtcl_pkg::KIND_LATCH;
			default:              kind_d = rtcl_pkg::KIND_NOP;
		endcase
	end

	assign push                = valid_s3;
	assign push_item.kind      = kind_d;
	assign push_item.idx       = idx_s3;
	assign push_item.wdata     = wdata_s3;
	assign push_item.ldata     = ldata_s3;
	assign push_item.sec_part  = sec_s3;
	assign push_item.min_part  = min_s3;
	assign push_item.hour_part = hour_full[4:0];
	assign push_item.day_part  = days_d;

endmodule

// ===== hdl/rtcl_queue.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue between the decode pipeline and the register file.
module rtcl_queue #(
	parameter int DEPTH = rtcl_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rtcl_pkg::item_t push_item,
	input  logic            pop,
	output logic            head_valid,
	output rtcl_pkg::item_t head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtcl_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

endmodule

// ===== hdl/rtcl_back.sv =====
`timescale 1ns / 1ps
// Register file: carries out advance, read, write and latch work in order.
module rtcl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  rtcl_pkg::item_t head_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      read_data
);

	logic [7:0] live_q    [rtcl_pkg::REG_COUNT];
	logic [7:0] latched_q [rtcl_pkg::REG_COUNT];
	logic       latch_flag_q;
	logic       out_valid_q;
	logic [7:0] read_data_q;

	logic [7:0]  sec_sum, sec_new;
	logic [7:0]  min_inc, min_sum, min_new;
	logic [7:0]  hour_inc, hour_sum, hour_new;
	logic        c_sec, c_min, c_hour;
	logic [16:0] days;
	logic [7:0]  dayh_new;
	logic [7:0]  read_value;
	logic        is_read;

	// Each field is added modulo 256 and then reduced once by its modulus.
	always_comb begin
		sec_sum  = live_q[rtcl_pkg::REG_SEC] + 8'(head_item.sec_part);
		c_sec    = (sec_sum >= rtcl_pkg::SEC_MOD);
		sec_new  = c_sec ? sec_sum - rtcl_pkg::SEC_MOD : sec_sum;

		min_inc  = live_q[rtcl_pkg::REG_MIN] + 8'(c_sec);
		min_sum  = min_inc + 8'(head_item.min_part);
		c_min    = (min_sum >= rtcl_pkg::MIN_MOD);
		min_new  = c_min ? min_sum - rtcl_pkg::MIN_MOD : min_sum;

		hour_inc = live_q[rtcl_pkg::REG_HOUR] + 8'(c_min);
		hour_sum = hour_inc + 8'(head_item.hour_part);
		c_hour   = (hour_sum >= rtcl_pkg::HOUR_MOD);
		hour_new = c_hour ? hour_sum - rtcl_pkg::HOUR_MOD : hour_sum;

		days = 17'({live_q[rtcl_pkg::REG_DAYH][0], live_q[rtcl_pkg::REG_DAYL]})
			+ 17'(head_item.day_part) + 17'(c_hour);
		// The day carry is sticky: set when the count passes 511, kept otherwise.
		dayh_new = {live_q[rtcl_pkg::REG_DAYH][7] | (|days[16:9]),
			live_q[rtcl_pkg::REG_DAYH][6:1], days[8]};
	end

	always_comb begin
		if (head_item.idx < 3'(rtcl_pkg::REG_COUNT)) begin
			read_value = latch_flag_q ? latched_q[head_item.idx] : live_q[head_item.idx];
		end else begin
			read_value = 8'd0;
		end
	end

	assign is_read = (head_item.kind == rtcl_pkg::KIND_READ);
	assign pop     = head_valid && (!is_read || !out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rtcl_pkg::REG_COUNT; i++) begin
				live_q[i]    <= 8'd0;
				latched_q[i] <= 8'd0;
			end
			latch_flag_q <= 1'b0;
		end else if (pop) begin
			case (head_item.kind)
				rtcl_pkg::KIND_ADVANCE: begin
					live_q[rtcl_pkg::REG_SEC]  <= sec_new;
					live_q[rtcl_pkg::REG_MIN]  <= min_new;
					live_q[rtcl_pkg::REG_HOUR] <= hour_new;
					live_q[rtcl_pkg::REG_DAYL] <= days[7:0];
					live_q[rtcl_pkg::REG_DAYH] <= dayh_new;
				end
				rtcl_pkg::KIND_WRITE: begin
					live_q[head_item.idx] <= head_item.wdata;
				end
				rtcl_pkg::KIND_LATCH: begin
					if (!latch_flag_q && head_item.ldata == 8'd1) begin
						for (int i = 0; i < rtcl_pkg::REG_COUNT; i++) begin
							latched_q[i] <= live_q[i];
						end
					end
					latch_flag_q <= head_item.ldata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && is_read) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_read) begin
			read_data_q <= read_value;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

// ===== hdl/cartridge_rtc_latch_clock_core.sv =====
`timescale 1ns / 1ps
// A read passes the decode pipeline, the queue and the register file before its result shows.
// Throughput: one transfer per cycle on each side while not stalled; the register file does
// each operation on pop; the rate is set by that single update loop and the queue's credit count.
// Reset: arst_n clears the live and latched registers, the latch flag, the queue and the
// output valid flag at once; the block takes transfers as soon as reset is released.
// Top level of the cartridge real-time clock with latch.
module cartridge_rtc_latch_clock_core #(
	parameter int QUEUE_DEPTH = rtcl_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] elapsed_seconds,
	input  logic [2:0]  register_index,
	input  logic [7:0]  write_data,
	input  logic [7:0]  latch_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// The front part is a three-stage pipeline that never stops: it turns
	// elapsed seconds into second, minute, hour and day parts with
	// reciprocal multiplications and classifies each operation. Its output
	// lands in the queue, from which the register file takes one item per
	// cycle. A read waits at the head only while the output register holds
	// an untaken result; all other work goes on regardless.

	logic            in_take;
	logic            push;
	rtcl_pkg::item_t push_item;
	logic            pop;
	logic            head_valid;
	rtcl_pkg::item_t head_item;

	// Credits count every item between the input transfer and the moment
	// the register file retires it, whether still in the pipeline or in the
	// queue, so the queue can never overflow.
	logic [CNT_W-1:0] credit_q;

	assign in_stall = (credit_q == CNT_W'(QUEUE_DEPTH));
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({in_take, pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	rtcl_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_take         (in_take),
		.operation       (operation),
		.elapsed_seconds (elapsed_seconds),
		.register_index  (register_index),
		.write_data      (write_data),
		.latch_data      (latch_data),
		.push            (push),
		.push_item       (push_item)
	);

	rtcl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	rtcl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data)
	);

endmodule
